// ===== src/adaptive_frame_sampler_top_macros.svh =====
// assertion macros for the adaptive frame sampler checker
`ifndef ADAPTIVE_FRAME_SAMPLER_TOP_MACROS_SVH
`define ADAPTIVE_FRAME_SAMPLER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define AFS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adaptive frame sampler check failed");

// next-cycle implication, sampled on clk, off during reset
`define AFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adaptive frame sampler check failed");

`endif

// ===== src/afs_pkg.sv =====
// types, constants and helpers shared by the adaptive frame sampler
`timescale 1ns / 1ps
package afs_pkg;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 3'd4;

    localparam logic [31:0] RST_WINDOW = 32'd2000000;
    localparam logic [15:0] RST_TARGET = 16'd100;
    localparam logic [16:0] RST_ALPHA  = 17'd9830;
    localparam logic [19:0] RST_PERIOD = 20'd16667;

    localparam logic [63:0] PCG_MUL = 64'd6364136223846793005;
    localparam logic [63:0] PCG_INC = 64'd109;

    localparam int AVG_W     = 36;
    localparam int ACC_W     = 80;
    localparam int DIV_W     = 48;
    localparam int DEN_W     = 36;
    localparam int REM_W     = DEN_W + 1;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int DIV_CNT_W = 5;

    localparam logic [16:0]      ONE_Q16    = 17'd65536;
    localparam logic [ACC_W-1:0] EMA_ROUND  = 80'd32768;
    localparam logic [31:0]      MIN_TLEFT  = 32'd1000;
    localparam logic [19:0]      MIN_DT     = 20'd10;
    localparam logic [DIV_W-1:0] FPS_NUM    = 48'd65536000000;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_EMA_NEW, ST_EMA_LO, ST_EMA_HI, ST_EMA_WR,
        ST_RNG_LL, ST_RNG_LH, ST_RNG_HL, ST_RNG_WR, ST_FL_DIV,
        ST_CMP_LO, ST_CMP_HI, ST_CMP_EVAL, ST_FPS_DIV, ST_FINISH
    } afs_state_t;

    typedef enum logic [2:0] {
        MAC_EMA_NEW, MAC_EMA_LO, MAC_EMA_HI, MAC_RNG_LL,
        MAC_RNG_LH, MAC_RNG_HL, MAC_CMP_LO, MAC_CMP_HI
    } afs_mac_sel_t;

    typedef struct packed {
        logic         capture;
        logic         prep;
        logic         mac_en;
        afs_mac_sel_t mac_sel;
        logic         avg_write;
        logic         rng_draw;
        logic         rng_write;
        logic         seed_done;
        logic         div_fl_load;
        logic         div_fps_load;
        logic         div_step;
        logic         cmp_eval;
        logic         take;
        logic         out_load;
    } afs_cmd_t;

    typedef struct packed {
        logic op;
        logic done;
        logic avg_zero;
        logic cmp_less;
        logic div_last;
        logic seed_pending;
        logic out_free;
    } afs_status_t;

    // pcg32 output permutation (xorshift high, random rotate)
    function automatic logic [31:0] pcg_output(input logic [63:0] old);
        logic [63:0] t;
        logic [31:0] x;
        logic [4:0]  rot;
        logic [63:0] dbl;
        t   = (old >> 18) ^ old;
        x   = t[58:27];
        rot = old[63:59];
        dbl = {x, x} >> rot;
        return dbl[31:0];
    endfunction

endpackage

// ===== src/afs_ctrl.sv =====
// sequencer for the adaptive frame sampler
`timescale 1ns / 1ps
module afs_ctrl
    import afs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  afs_status_t status,
    output afs_cmd_t    cmd
);

    afs_state_t state_reg;
    afs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mac_sel = MAC_EMA_NEW;
        in_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (status.seed_pending)
                begin
                    state_next = ST_RNG_LL;
                end
                else
                begin
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = status.op ? ST_FINISH : ST_EMA_NEW;
            end
            ST_EMA_NEW:
            begin
                cmd.mac_en  = 1'b1;
                cmd.mac_sel = MAC_EMA_NEW;
                state_next  = ST_EMA_LO;
            end
            ST_EMA_LO:
            begin
                cmd.mac_en  = 1'b1;
                cmd.mac_sel = MAC_EMA_LO;
                state_next  = ST_EMA_HI;
            end
            ST_EMA_HI:
            begin
                cmd.mac_en  = 1'b1;
                cmd.mac_sel = MAC_EMA_HI;
                state_next  = ST_EMA_WR;
            end
            ST_EMA_WR:
            begin
                cmd.avg_write = 1'b1;
                state_next    = status.done ? ST_FINISH : ST_RNG_LL;
            end
            ST_RNG_LL:
            begin
                cmd.mac_en   = 1'b1;
                cmd.mac_sel  = MAC_RNG_LL;
                cmd.rng_draw = !status.seed_pending;
                state_next   = ST_RNG_LH;
            end
            ST_RNG_LH:
            begin
                cmd.mac_en  = 1'b1;
                cmd.mac_sel = MAC_RNG_LH;
                state_next  = ST_RNG_HL;
            end
            ST_RNG_HL:
            begin
                cmd.mac_en  = 1'b1;
                cmd.mac_sel = MAC_RNG_HL;
                state_next  = ST_RNG_WR;
            end
            ST_RNG_WR:
            begin
                cmd.rng_write = 1'b1;
                if (status.seed_pending)
                begin
                    cmd.seed_done = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (status.avg_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.div_fl_load = 1'b1;
                    state_next      = ST_FL_DIV;
                end
            end
            ST_FL_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_CMP_LO;
                end
            end
            ST_CMP_LO:
            begin
                cmd.mac_en  = 1'b1;
                cmd.mac_sel = MAC_CMP_LO;
                state_next  = ST_CMP_HI;
            end
            ST_CMP_HI:
            begin
                cmd.mac_en  = 1'b1;
                cmd.mac_sel = MAC_CMP_HI;
                state_next  = ST_CMP_EVAL;
            end
            ST_CMP_EVAL:
            begin
                cmd.cmp_eval = 1'b1;
                if (status.cmp_less)
                begin
                    cmd.take         = 1'b1;
                    cmd.div_fps_load = 1'b1;
                    state_next       = ST_FPS_DIV;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FPS_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/afs_datapath.sv =====
// state, configuration, shared multiply-accumulate and serial divider
`timescale 1ns / 1ps
module afs_datapath
    import afs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_wdata,
    input  logic                 op,
    input  logic [19:0]          frame_dt_us,
    input  logic [47:0]          now_us,
    input  logic [63:0]          frame_number,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic                 taken,
    output logic                 window_done,
    output logic [31:0]          elapsed_us,
    output logic [32:0]          fps_q16,
    output logic [15:0]          taken_count,
    output logic [63:0]          first_frame,
    output logic [63:0]          last_frame,
    input  afs_cmd_t             cmd,
    output afs_status_t          status
);

    // configuration
    logic [31:0]      window_reg;
    logic [15:0]      target_reg;
    logic [16:0]      alpha_reg;
    logic             seed_pending_reg;

    // block state
    logic             started_reg;
    logic [47:0]      start_time_reg;
    logic [63:0]      start_frame_reg;
    logic [63:0]      end_frame_reg;
    logic [AVG_W-1:0] avg_reg;
    logic [15:0]      count_reg;
    logic [63:0]      rng_reg;

    // per-request working registers
    logic             op_reg;
    logic [19:0]      dt_reg;
    logic [47:0]      now_reg;
    logic [63:0]      frame_reg;
    logic [47:0]      elapsed_reg;
    logic             done_reg;
    logic             taken_reg;
    logic [31:0]      rnd_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [DIV_W-1:0] div_num_reg;
    logic [REM_W-1:0] div_rem_reg;
    logic [DEN_W-1:0] div_den_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // result register
    logic             out_valid_reg;
    logic             out_taken_reg;
    logic             out_done_reg;
    logic [31:0]      out_elapsed_reg;
    logic [32:0]      out_fps_reg;
    logic [15:0]      out_count_reg;
    logic [63:0]      out_first_reg;
    logic [63:0]      out_last_reg;

    logic [16:0]      alpha_c;
    logic [16:0]      alpha_inv;
    logic [47:0]      eff_start;
    logic [47:0]      elapsed_full;
    logic [31:0]      tleft_raw;
    logic [31:0]      tleft;
    logic [15:0]      remaining;
    logic [19:0]      sdt;
    logic [DIV_W-1:0] frames_left;
    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [63:0]      prod;
    logic [5:0]       mac_sh;
    logic             mac_first;
    logic [ACC_W-1:0] acc_base;
    logic [ACC_W-1:0] acc_next;
    logic [AVG_W-1:0] avg_next;
    logic [63:0]      rng_next;
    logic [DIV_W-1:0] num_next;
    logic [REM_W-1:0] rem_next;
    logic [REM_W-1:0] trial;

    assign alpha_c   = (alpha_reg > ONE_Q16) ? ONE_Q16 : alpha_reg;
    assign alpha_inv = ONE_Q16 - alpha_c;

    // a time earlier than the window start counts as no time gone by
    assign eff_start    = started_reg ? start_time_reg : now_reg;
    assign elapsed_full = (now_reg >= eff_start) ? (now_reg - eff_start) : 48'd0;

    assign tleft_raw   = window_reg - elapsed_reg[31:0];
    assign tleft       = (tleft_raw < MIN_TLEFT) ? MIN_TLEFT : tleft_raw;
    assign remaining   = (target_reg > count_reg) ? (target_reg - count_reg) : 16'd0;
    assign sdt         = (dt_reg < MIN_DT) ? MIN_DT : dt_reg;
    assign frames_left = (div_num_reg == '0) ? DIV_W'(1) : div_num_reg;

    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        mac_sh    = 6'd0;
        mac_first = 1'b0;
        unique case (cmd.mac_sel)
            MAC_EMA_NEW:
            begin
                mul_a     = 32'(alpha_c);
                mul_b     = 32'(dt_reg);
                mac_sh    = 6'd16;
                mac_first = 1'b1;
            end
            MAC_EMA_LO:
            begin
                mul_a = 32'(alpha_inv);
                mul_b = avg_reg[31:0];
            end
            MAC_EMA_HI:
            begin
                mul_a  = 32'(alpha_inv);
                mul_b  = 32'(avg_reg[AVG_W-1:32]);
                mac_sh = 6'd32;
            end
            MAC_RNG_LL:
            begin
                mul_a     = rng_reg[31:0];
                mul_b     = PCG_MUL[31:0];
                mac_first = 1'b1;
            end
            MAC_RNG_LH:
            begin
                mul_a  = rng_reg[31:0];
                mul_b  = PCG_MUL[63:32];
                mac_sh = 6'd32;
            end
            MAC_RNG_HL:
            begin
                mul_a  = rng_reg[63:32];
                mul_b  = PCG_MUL[31:0];
                mac_sh = 6'd32;
            end
            MAC_CMP_LO:
            begin
                mul_a     = rnd_reg;
                mul_b     = frames_left[31:0];
                mac_first = 1'b1;
            end
            MAC_CMP_HI:
            begin
                mul_a  = rnd_reg;
                mul_b  = 32'(frames_left[DIV_W-1:32]);
                mac_sh = 6'd32;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign prod     = 64'(mul_a) * 64'(mul_b);
    assign acc_base = mac_first ? ((cmd.mac_sel == MAC_EMA_NEW) ? EMA_ROUND : '0) : acc_reg;
    assign acc_next = acc_base + (ACC_W'(prod) << mac_sh);
    assign avg_next = acc_reg[AVG_W+15:16];
    assign rng_next = acc_reg[63:0] + PCG_INC;

    // two restoring division steps per cycle
    always_comb
    begin
        num_next = div_num_reg;
        rem_next = div_rem_reg;
        trial    = '0;
        for (int i = 0; i < 2; i++)
        begin
            trial    = {rem_next[REM_W-2:0], num_next[DIV_W-1]};
            num_next = {num_next[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, div_den_reg})
            begin
                rem_next    = trial - {1'b0, div_den_reg};
                num_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg       <= RST_WINDOW;
            target_reg       <= RST_TARGET;
            alpha_reg        <= RST_ALPHA;
            seed_pending_reg <= 1'b1;
            started_reg      <= 1'b0;
            start_time_reg   <= '0;
            start_frame_reg  <= '0;
            end_frame_reg    <= '0;
            avg_reg          <= {RST_PERIOD, 16'd0};
            count_reg        <= '0;
            rng_reg          <= PCG_INC;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WINDOW: window_reg <= cfg_wdata[31:0];
                    CFG_TARGET: target_reg <= cfg_wdata[15:0];
                    CFG_ALPHA:  alpha_reg  <= cfg_wdata[16:0];
                    CFG_PERIOD: avg_reg    <= {cfg_wdata[19:0], 16'd0};
                    CFG_SEED:
                    begin
                        // reseed: state = (seed + inc) then one advance
                        rng_reg          <= cfg_wdata + PCG_INC;
                        seed_pending_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (cmd.seed_done)
            begin
                seed_pending_reg <= 1'b0;
            end
            if (cmd.prep)
            begin
                if (op_reg)
                begin
                    started_reg     <= 1'b1;
                    start_time_reg  <= now_reg;
                    start_frame_reg <= '0;
                    end_frame_reg   <= '0;
                    count_reg       <= '0;
                end
                else if (!started_reg)
                begin
                    started_reg     <= 1'b1;
                    start_time_reg  <= now_reg;
                    start_frame_reg <= frame_reg;
                end
            end
            if (cmd.avg_write)
            begin
                avg_reg <= avg_next;
            end
            if (cmd.rng_write)
            begin
                rng_reg <= rng_next;
            end
            if (cmd.take)
            begin
                end_frame_reg <= frame_reg;
                count_reg     <= count_reg + 16'd1;
                if (start_frame_reg == '0)
                begin
                    start_frame_reg <= frame_reg;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            dt_reg    <= frame_dt_us;
            now_reg   <= now_us;
            frame_reg <= frame_number;
            taken_reg <= 1'b0;
        end
        if (cmd.prep)
        begin
            if (op_reg)
            begin
                elapsed_reg <= '0;
                done_reg    <= (window_reg == '0);
            end
            else
            begin
                elapsed_reg <= elapsed_full;
                done_reg    <= (elapsed_full >= 48'(window_reg));
            end
        end
        if (cmd.mac_en)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.rng_draw)
        begin
            rnd_reg <= pcg_output(rng_reg);
        end
        if (cmd.cmp_eval)
        begin
            taken_reg <= status.cmp_less;
        end
        if (cmd.div_fl_load)
        begin
            div_num_reg <= {tleft, 16'd0};
            div_den_reg <= avg_reg;
            div_rem_reg <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_fps_load)
        begin
            div_num_reg <= FPS_NUM + DIV_W'(sdt >> 1);
            div_den_reg <= DEN_W'(sdt);
            div_rem_reg <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_num_reg <= num_next;
            div_rem_reg <= rem_next;
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            out_taken_reg   <= taken_reg;
            out_done_reg    <= done_reg;
            out_elapsed_reg <= (elapsed_reg[47:32] != '0) ? '1 : elapsed_reg[31:0];
            out_fps_reg     <= taken_reg ? div_num_reg[32:0] : '0;
            out_count_reg   <= count_reg;
            out_first_reg   <= start_frame_reg;
            out_last_reg    <= end_frame_reg;
        end
    end

    assign status.op           = op_reg;
    assign status.done         = done_reg;
    assign status.avg_zero     = (avg_reg == '0);
    assign status.cmp_less     = (acc_reg < ACC_W'({remaining, 32'd0}));
    assign status.div_last     = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign status.seed_pending = seed_pending_reg;
    assign status.out_free     = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign taken       = out_taken_reg;
    assign window_done = out_done_reg;
    assign elapsed_us  = out_elapsed_reg;
    assign fps_q16     = out_fps_reg;
    assign taken_count = out_count_reg;
    assign first_frame = out_first_reg;
    assign last_frame  = out_last_reg;

endmodule

// ===== src/adaptive_frame_sampler_top.sv =====
// top level of the adaptive frame sampler
// usage:
//   one request per frame on the input channel (in_valid/in_ready): op 0 is a
//   frame tick, op 1 restarts the window at now_us. every request gives one
//   result on the output channel (out_valid/out_ready).
//   configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
// sequence, from the accepting edge to out_valid: restart runs prep, then
//   finish; a tick with window done runs prep, the ema multiply steps and the
//   average write, then finish; with a zero average it adds the pcg32 step;
//   inside the window it adds the frames-left division, the take test and, when
//   taken, the fps division. the next request is accepted back in idle after the
//   result is loaded. the cost is set by the shared 32x32 multiply-accumulate
//   (ema, pcg32, take test) and the 2-bit-per-cycle divider (frames left, fps).
// reset: the configuration, block state and out_valid registers return to their
//   defaults and the generator is seeded, a pass through the pcg32 step during
//   which in_ready stays low; writing the seed register runs the same pass.
// stall: a result waits in the output register; the block holds its next
//   finished result, accepting no new request, until the slot frees.
`timescale 1ns / 1ps
module adaptive_frame_sampler_top
    import afs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 op,
    input  logic [19:0]          frame_dt_us,
    input  logic [47:0]          now_us,
    input  logic [63:0]          frame_number,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 taken,
    output logic                 window_done,
    output logic [31:0]          elapsed_us,
    output logic [32:0]          fps_q16,
    output logic [15:0]          taken_count,
    output logic [63:0]          first_frame,
    output logic [63:0]          last_frame
);

    afs_cmd_t    cmd;
    afs_status_t status;

    afs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    afs_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .op           (op),
        .frame_dt_us  (frame_dt_us),
        .now_us       (now_us),
        .frame_number (frame_number),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .taken        (taken),
        .window_done  (window_done),
        .elapsed_us   (elapsed_us),
        .fps_q16      (fps_q16),
        .taken_count  (taken_count),
        .first_frame  (first_frame),
        .last_frame   (last_frame),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

// ===== src/afs_checker.sv =====
// port-level checks for the adaptive frame sampler, bound to the top level
`timescale 1ns / 1ps
`include "adaptive_frame_sampler_top_macros.svh"
module afs_checker
    import afs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        taken,
    input logic        window_done,
    input logic [32:0] fps_q16,
    input logic [15:0] taken_count
);

    // a stalled result holds
    `AFS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(fps_q16))

    // fps is only reported for a sampled frame
    `AFS_ASSERT_NOW(a_fps_zero, out_valid && !taken, fps_q16 == 33'd0)

    // a sampled frame lies inside the window and counts
    `AFS_ASSERT_NOW(a_taken_open, out_valid && taken, !window_done && taken_count != 16'd0)

    // one request at a time
    `AFS_ASSERT_NEXT(a_one_req, in_valid && in_ready, !in_ready)

endmodule

bind adaptive_frame_sampler_top afs_checker u_afs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .taken       (taken),
    .window_done (window_done),
    .fps_q16     (fps_q16),
    .taken_count (taken_count)
);

// ===== tb/testbench.sv =====
// self-checking testbench for the adaptive frame sampler top level
`timescale 1ns / 1ps
module testbench;
    import afs_pkg::*;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_RESTART = 1'b1;
    localparam int   DRAIN_CYCLES = 80;

    typedef struct packed {
        logic        taken;
        logic        window_done;
        logic [31:0] elapsed_us;
        logic [32:0] fps_q16;
        logic [15:0] taken_count;
        logic [63:0] first_frame;
        logic [63:0] last_frame;
    } sample_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW;
    logic [63:0] cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        op = OP_TICK;
    logic [19:0] frame_dt_us = '0;
    logic [47:0] now_us = '0;
    logic [63:0] frame_number = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        taken;
    logic        window_done;
    logic [31:0] elapsed_us;
    logic [32:0] fps_q16;
    logic [15:0] taken_count;
    logic [63:0] first_frame;
    logic [63:0] last_frame;

    // model copy of configuration and state
    logic [31:0] m_window;
    logic [15:0] m_target;
    logic [16:0] m_alpha;
    logic [19:0] m_period;
    logic        m_started;
    logic [47:0] m_start_time;
    logic [63:0] m_start_frame;
    logic [63:0] m_end_frame;
    logic [63:0] m_avg;
    logic [15:0] m_taken;
    logic [63:0] m_rng;

    sample_t     sample_q[$];
    int          errors = 0;
    int          results_seen = 0;
    int          takes_seen = 0;
    int          items_sent = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_cycles = 0;
    logic [47:0] cur_now = '0;
    logic [63:0] cur_frame = 64'd1;

    adaptive_frame_sampler_top dut (.*);

    always #1 clk = ~clk;

    function automatic logic [63:0] pcg_seeded(input logic [63:0] seed);
        return (PCG_INC + seed) * PCG_MUL + PCG_INC;
    endfunction

    function automatic logic [31:0] pcg_draw();
        logic [63:0] old;
        logic [31:0] x;
        logic [4:0]  rot;
        old   = m_rng;
        m_rng = old * PCG_MUL + PCG_INC;
        x     = 32'(((old >> 18) ^ old) >> 27);
        rot   = old[63:59];
        return (x >> rot) | (x << ((32 - rot) & 31));
    endfunction

    function automatic sample_t predict_sample(input logic o, input logic [19:0] dt,
                                               input logic [47:0] now, input logic [63:0] fr);
        sample_t     s;
        logic [63:0] a;
        logic [63:0] el;
        logic [63:0] tleft;
        logic [63:0] remaining;
        logic [63:0] fl;
        logic [63:0] sdt;
        logic [127:0] prod;
        logic [31:0] r;
        s = '0;
        if (o == OP_RESTART) begin
            m_started = 1'b1;
            m_start_time = now;
            m_start_frame = '0;
            m_end_frame = '0;
            m_taken = '0;
            el = 0;
            s.window_done = (m_window == 0);
        end
        else begin
            a = (m_alpha > 17'd65536) ? 64'd65536 : 64'(m_alpha);
            if (!m_started) begin
                m_started = 1'b1;
                m_start_time = now;
                m_start_frame = fr;
            end
            m_avg = (a * (64'(dt) << 16) + (64'd65536 - a) * m_avg + 64'd32768) >> 16;
            el = (now >= m_start_time) ? 64'(now - m_start_time) : 64'd0;
            s.window_done = (el >= 64'(m_window));
            if (!s.window_done) begin
                tleft = 64'(m_window) - el;
                remaining = (m_target > m_taken) ? 64'(m_target - m_taken) : 64'd0;
                if (tleft < 64'd1000)
                    tleft = 64'd1000;
                r = pcg_draw();
                if (m_avg != 0) begin
                    fl = (tleft << 16) / m_avg;
                    if (fl < 1)
                        fl = 1;
                    prod = 128'(r) * 128'(fl);
                    s.taken = (prod < 128'(remaining << 32));
                end
                if (s.taken) begin
                    sdt = (dt < 20'd10) ? 64'd10 : 64'(dt);
                    m_end_frame = fr;
                    if (m_start_frame == 0)
                        m_start_frame = fr;
                    m_taken = m_taken + 16'd1;
                    s.fps_q16 = 33'((64'd65536000000 + sdt / 2) / sdt);
                end
            end
        end
        s.elapsed_us = (el > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : el[31:0];
        s.taken_count = m_taken;
        s.first_frame = m_start_frame;
        s.last_frame = m_end_frame;
        return s;
    endfunction

    task automatic model_reset();
        m_window = RST_WINDOW;
        m_target = RST_TARGET;
        m_alpha = RST_ALPHA;
        m_period = RST_PERIOD;
        m_started = 1'b0;
        m_start_time = '0;
        m_start_frame = '0;
        m_end_frame = '0;
        m_taken = '0;
        m_avg = 64'(RST_PERIOD) << 16;
        m_rng = pcg_seeded(64'd0);
    endtask

    // one request, held until accepted; valid stays up when no gap follows
    task automatic send_frame(input logic o, input logic [19:0] dt,
                              input logic [47:0] now, input logic [63:0] fr);
        int gap;
        in_valid <= 1'b1;
        op <= o;
        frame_dt_us <= dt;
        now_us <= now;
        frame_number <= fr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sample_q.push_back(predict_sample(o, dt, now, fr));
        items_sent++;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sample_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WINDOW: m_window = val[31:0];
            CFG_TARGET: m_target = val[15:0];
            CFG_ALPHA:  m_alpha = val[16:0];
            CFG_PERIOD:
            begin
                m_period = val[19:0];
                m_avg = 64'(m_period) << 16;
            end
            CFG_SEED:   m_rng = pcg_seeded(val);
            default:    ;
        endcase
    endtask

    task automatic configure(input logic [31:0] win, input logic [15:0] tgt,
                             input logic [16:0] alpha, input logic [19:0] period,
                             input logic [63:0] seed);
        wait_idle();
        write_reg(CFG_WINDOW, 64'(win));
        write_reg(CFG_TARGET, 64'(tgt));
        write_reg(CFG_ALPHA, 64'(alpha));
        write_reg(CFG_PERIOD, 64'(period));
        write_reg(CFG_SEED, seed);
        @(posedge clk);
    endtask

    task automatic test_defaults();
        send_frame(OP_TICK, 20'd16667, 48'd1000, 64'd0);
        send_frame(OP_TICK, 20'd0, 48'd17000, 64'd1);
        send_frame(OP_TICK, 20'd5, 48'd18000, 64'd2);
        send_frame(OP_TICK, 20'd1000000, 48'd50000, 64'hFFFF_FFFF_FFFF_FFFF);
        // time going backwards
        send_frame(OP_TICK, 20'd16000, 48'd10, 64'd4);
        send_frame(OP_RESTART, 20'hAAAAA, 48'd60000, 64'h5555_5555_5555_5555);
        send_frame(OP_TICK, 20'h55555, 48'd2100000, 64'hAAAA_AAAA_AAAA_AAAA);
        send_frame(OP_RESTART, 20'd0, 48'hFFFF_FFFF_FFFF, 64'd0);
        send_frame(OP_TICK, 20'd33000, 48'hFFFF_FFFF_FFFF, 64'd7);
        send_frame(OP_TICK, 20'd16000, 48'd0, 64'd8);
        cur_now = 48'd0;
    endtask

    task automatic test_extremes();
        // zero window length, alpha beyond one
        configure(32'd0, 16'd0, 17'h1FFFF, 20'd1000, 64'd0);
        send_frame(OP_RESTART, 20'd0, 48'd5, 64'd0);
        send_frame(OP_TICK, 20'd0, 48'd6, 64'd1);
        // zero average: full alpha with zero frame time
        configure(32'hFFFF_FFFF, 16'hFFFF, 17'd65536, 20'd1000000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(OP_RESTART, 20'd0, 48'd100, 64'd0);
        send_frame(OP_TICK, 20'd0, 48'd200, 64'd2);
        send_frame(OP_TICK, 20'd0, 48'd300, 64'd3);
        send_frame(OP_TICK, 20'd9, 48'd400, 64'd4);
        send_frame(OP_TICK, 20'd1, 48'd500, 64'd5);
        // count full: tiny target in a short window
        configure(32'd1, 16'd1, 17'd0, 20'd1000, 64'd0);
        send_frame(OP_RESTART, 20'd0, 48'd1000, 64'd0);
        send_frame(OP_TICK, 20'd10, 48'd1000, 64'd10);
        send_frame(OP_TICK, 20'd10, 48'd1000, 64'd11);
        send_frame(OP_TICK, 20'd10, 48'd1001, 64'd12);
    endtask

    task automatic random_frame();
        int p;
        logic [19:0] dt;
        p = $urandom_range(99);
        if (p < 3) begin
            send_frame(OP_RESTART, 20'($urandom_range(1000000)), cur_now, {$urandom, $urandom});
        end
        else if (p < 6) begin
            send_frame(OP_TICK, 20'($urandom_range(30000)),
                       cur_now - 48'($urandom_range(int'(cur_now > 5000 ? 5000 : cur_now))),
                       cur_frame);
        end
        else if (p < 10) begin
            dt = 20'($urandom_range(1000000));
            cur_now = cur_now + 48'(dt);
            send_frame(OP_TICK, dt, cur_now, {$urandom, $urandom});
        end
        else begin
            dt = (p < 14) ? 20'($urandom_range(20)) : 20'($urandom_range(40000, 8000));
            cur_now = cur_now + 48'(dt);
            cur_frame = cur_frame + 64'd1;
            send_frame(OP_TICK, dt, cur_now, cur_frame);
        end
    endtask

    task automatic test_random(input int n, input int s_idle, input int r_idle,
                               input int hold);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        hold_cycles = hold;
        repeat (n) random_frame();
    endtask

    task automatic test_settings_sweep();
        configure(32'd300000, 16'd20, 17'd20000, 20'd20000, {$urandom, $urandom});
        test_random(640, 15, 52, 0);
        configure(32'd1500000, 16'd60, 17'd65535, 20'd1000, {$urandom, $urandom});
        test_random(640, 52, 15, 0);
        configure(32'd100000, 16'd8, 17'd9830, 20'd16667, 64'hDEAD_BEEF_0123_4567);
        test_random(640, 0, 0, 400);
    endtask

    // receiver with a counted hold-off when asked
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        sample_t e;
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (sample_q.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end
            else begin
                e = sample_q.pop_front();
                if (taken) takes_seen++;
                if (taken !== e.taken) begin
                    $error("taken exp %0d got %0d", e.taken, taken); errors++;
                end
                if (window_done !== e.window_done) begin
                    $error("window_done exp %0d got %0d", e.window_done, window_done); errors++;
                end
                if (elapsed_us !== e.elapsed_us) begin
                    $error("elapsed_us exp %0d got %0d", e.elapsed_us, elapsed_us); errors++;
                end
                if (fps_q16 !== e.fps_q16) begin
                    $error("fps_q16 exp %0d got %0d", e.fps_q16, fps_q16); errors++;
                end
                if (taken_count !== e.taken_count) begin
                    $error("taken_count exp %0d got %0d", e.taken_count, taken_count); errors++;
                end
                if (first_frame !== e.first_frame) begin
                    $error("first_frame exp %h got %h", e.first_frame, first_frame); errors++;
                end
                if (last_frame !== e.last_frame) begin
                    $error("last_frame exp %h got %h", e.last_frame, last_frame); errors++;
                end
            end
        end
    end

    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        model_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_extremes();
        test_settings_sweep();
        wait_idle();
        if (sample_q.size() != 0) begin
            $error("%0d results never arrived", sample_q.size());
            errors++;
        end
        $display("covered %0d requests, %0d results, %0d frames taken",
                 items_sent, results_seen, takes_seen);
        $display("settings swept from zero window to full range, with stalls and hold-off");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
